[hdl/lsc_pkg.sv]
// Shared constants, codes and types of the LIFO stack with compaction.
package lsc_pkg;

   // Default geometry of the entry store.
   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;

   // Fixed widths of the channel fields.
   localparam int OP_W  = 2;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int ENT_W = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_UNDER = 2'd1;
   localparam logic [ST_W-1:0] ST_OVER  = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

   // One finished result, handed from the controller to the output register.
   typedef struct packed {
      logic             load;
      logic [VAL_W-1:0] value;
      logic [ST_W-1:0]  status;
      logic [ENT_W-1:0] entries;
   } res_type;

endpackage

[hdl/lsc_mem.sv]
// Entry store: one write port, one read port with registered read data.
module lsc_mem
   import lsc_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int AW       = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] store_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lsc_ctrl.sv]
// Stack controller: entry count, operation sequencing and compaction walk.
module lsc_ctrl
   import lsc_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   localparam int AW       = $clog2(DEPTH),
   localparam int CW       = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [OP_W-1:0]      op,
   input  logic [WORD_BITS-1:0] word,
   output logic                 idle,
   output res_type              res,
   output logic                 mem_we,
   output logic [AW-1:0]        mem_waddr,
   output logic [WORD_BITS-1:0] mem_wdata,
   output logic                 mem_re,
   output logic [AW-1:0]        mem_raddr,
   input  logic [WORD_BITS-1:0] mem_rdata
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_CMP  = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] cnt_dec;
   logic [CW-1:0] cnt_inc;
   logic          issue;

   assign cnt_dec = count_ff - CW'(1);
   assign cnt_inc = count_ff + CW'(1);
   assign issue   = (rd_ptr_ff != count_ff);
   assign idle    = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      res       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res.load    = 1'b1;
               res.status  = ST_OK;
               res.entries = ENT_W'(count_ff);
               case (op)
                  OP_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        res.status = ST_OVER;
                     end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_ff[AW-1:0];
                        mem_wdata   = word;
                        count_in    = cnt_inc;
                        res.entries = ENT_W'(cnt_inc);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res.status = ST_UNDER;
                     end else begin
                        // read the top entry; the result follows next cycle
                        res.load  = 1'b0;
                        mem_re    = 1'b1;
                        mem_raddr = cnt_dec[AW-1:0];
                        state_in  = S_POP;
                     end
                  end
                  OP_COMPACT: begin
                     if (count_ff == '0) begin
                        res.status = ST_EMPTY;
                     end else begin
                        res.load  = 1'b0;
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                        state_in  = S_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            // clear the popped slot and drop the count
            mem_we      = 1'b1;
            mem_waddr   = cnt_dec[AW-1:0];
            mem_wdata   = '0;
            count_in    = cnt_dec;
            res.load    = 1'b1;
            res.value   = VAL_W'(mem_rdata);
            res.status  = ST_OK;
            res.entries = ENT_W'(cnt_dec);
            state_in    = S_IDLE;
         end
         S_CMP: begin
            // read ahead one entry; writes trail reads so they never collide
            if (issue) begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff[AW-1:0];
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            pend_in = issue;
            if (pend_ff && (mem_rdata != '0)) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff[AW-1:0];
               mem_wdata = mem_rdata;
               wr_ptr_in = wr_ptr_ff + CW'(1);
            end
            if (!issue && !pend_ff) begin
               count_in    = wr_ptr_ff;
               res.load    = 1'b1;
               res.status  = ST_OK;
               res.entries = ENT_W'(wr_ptr_ff);
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         pend_ff   <= pend_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_wr_trails_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (wr_ptr_ff <= rd_ptr_ff))
      else $error("compaction write pointer passed read pointer");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same entry in one cycle");
`endif

endmodule

[hdl/lifo_stack_with_compaction.sv]
// LIFO stack with compaction: top level with output register.
// Push, unknown op and every error case give the result in the cycle after
// accept; pop first reads the top entry, then clears it and gives the result;
// compact does one memory read per stored entry.
// One item at a time: a new request is taken only when the controller is idle
// and the output register is free.
// Reset clears the entry count; the store itself is not cleared.
module lifo_stack_with_compaction
   import lsc_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_op,
   input  logic [VAL_W-1:0] req_push_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_pop_value,
   output logic [ST_W-1:0]  rsp_status,
   output logic [ENT_W-1:0] rsp_entries_now
);

   localparam int AW = $clog2(DEPTH);

   logic                 idle;
   logic                 out_free;
   logic                 accept;
   res_type              res;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;
   logic [WORD_BITS-1:0] mem_rdata;

   logic             rsp_valid_ff;
   logic [VAL_W-1:0] pop_value_ff;
   logic [ST_W-1:0]  status_ff;
   logic [ENT_W-1:0] entries_ff;

   // The output register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Take a new item only when the controller is idle and the result can land.
   assign req_stall = !(idle && out_free);
   assign accept    = req_valid && !req_stall;

   lsc_ctrl #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_op),
      .word      (WORD_BITS'(req_push_value)),
      .idle      (idle),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   lsc_mem #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Hold the result until taken; load a new one when the controller finishes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         pop_value_ff <= res.value;
         status_ff    <= res.status;
         entries_ff   <= res.entries;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pop_value   = pop_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_entries_now = entries_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res.load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a stalled item");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      !idle |-> req_stall)
      else $error("input taken while the controller is busy");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable({pop_value_ff, status_ff, entries_ff})))
      else $error("stalled result changed");
`endif

endmodule
